>>> hw/rtl/rdpg_pkg.sv
// ----------------------------------------------------------------------------
// rdpg_pkg: shared types and constants of the radial disk pixel generator
// Holds the field widths, configuration register indexes and the request
// that travels down the square root cell chain.
// ----------------------------------------------------------------------------
package rdpg_pkg;

    // Fixed field widths.
    localparam int DIM_W    = 13;   // image width and height registers
    localparam int RADIUS_W = 12;   // disk radius register
    localparam int CTR_W    = 12;   // centre coordinate (dimension / 2)
    localparam int GREY_W   = 8;    // grey level

    // Every squared distance is rooted, but the root is only used while below radius squared.
    localparam int RAD_W  = 2 * RADIUS_W;   // radicand width
    localparam int ROOT_W = RADIUS_W;       // root width, one bit per cell
    localparam int REM_W  = ROOT_W + 1;     // partial remainder width

    localparam logic [GREY_W-1:0] GREY_MAX = 8'd255;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DISK_RADIUS  = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [DIM_W-1:0]    IMAGE_WIDTH_RST  = 13'd512;
    localparam logic [DIM_W-1:0]    IMAGE_HEIGHT_RST = 13'd512;
    localparam logic [RADIUS_W-1:0] DISK_RADIUS_RST  = 12'd100;

    // One request in flight through the root cell chain.
    typedef struct packed {
        logic              in_disk; // squared distance below radius squared
        logic [RAD_W-1:0]  rad;     // radicand bits not yet consumed, MSB first
        logic [REM_W-1:0]  rem;     // partial remainder
        logic [ROOT_W-1:0] root;    // root bits found so far
    } sq_bus_t;

endpackage

>>> hw/rtl/rdpg_front.sv
// ----------------------------------------------------------------------------
// rdpg_front: distance front end
// Three registered stages: absolute offsets to the centre, their squares,
// then the squared distance and its compare against radius squared.
// ----------------------------------------------------------------------------
module rdpg_front #(
    parameter int COORD_BITS = 12
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [COORD_BITS-1:0]          pixel_col,
    input  logic [COORD_BITS-1:0]          pixel_row,
    input  logic [rdpg_pkg::DIM_W-1:0]     image_width,
    input  logic [rdpg_pkg::DIM_W-1:0]     image_height,
    input  logic [rdpg_pkg::RAD_W-1:0]     radius_sq,
    output logic                           out_valid,
    input  logic                           out_ready,
    output rdpg_pkg::sq_bus_t              out_data
);
    import rdpg_pkg::*;

    localparam int DIFF_W = (COORD_BITS > CTR_W) ? COORD_BITS : CTR_W;
    localparam int SQ_W   = 2 * DIFF_W;
    localparam int SUM_W  = SQ_W + 1;

    logic              v1_reg, v2_reg, v3_reg;
    logic              rdy1, rdy2, rdy3;
    logic [DIFF_W-1:0] dx_reg, dy_reg, dx_next, dy_next;
    logic [SQ_W-1:0]   dx2_reg, dy2_reg, dx2_next, dy2_next;
    logic [DIFF_W-1:0] col_ext, row_ext, cx_ext, cy_ext;
    logic [SUM_W-1:0]  sum;
    sq_bus_t           data_reg, data_next;

    // Ready ripples back through empty stages.
    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // Stage 1: absolute offsets from the centre.
    always_comb begin
        col_ext = DIFF_W'(pixel_col);
        row_ext = DIFF_W'(pixel_row);
        cx_ext  = DIFF_W'(image_width[DIM_W-1:1]);
        cy_ext  = DIFF_W'(image_height[DIM_W-1:1]);
        dx_next = (col_ext >= cx_ext) ? (col_ext - cx_ext) : (cx_ext - col_ext);
        dy_next = (row_ext >= cy_ext) ? (row_ext - cy_ext) : (cy_ext - row_ext);
    end

    // Stage 2: squares of the offsets.
    always_comb begin
        dx2_next = SQ_W'(dx_reg) * SQ_W'(dx_reg);
        dy2_next = SQ_W'(dy_reg) * SQ_W'(dy_reg);
    end

    // Stage 3: squared distance, disk test and a fresh root request.
    always_comb begin
        sum               = SUM_W'(dx2_reg) + SUM_W'(dy2_reg);
        data_next.in_disk = sum < SUM_W'(radius_sq);
        data_next.rad     = sum[RAD_W-1:0];
        data_next.rem     = '0;
        data_next.root    = '0;
    end

    // Stage valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= in_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
        if (rdy2 && v1_reg) begin
            dx2_reg <= dx2_next;
            dy2_reg <= dy2_next;
        end
        if (rdy3 && v2_reg) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = data_reg;

endmodule

>>> hw/rtl/rdpg_sqrt_cell.sv
// ----------------------------------------------------------------------------
// rdpg_sqrt_cell: one step of the digit-by-digit square root
// Takes the next two radicand bits, decides one root bit and hands the
// request to the next cell through its own register.
// ----------------------------------------------------------------------------
module rdpg_sqrt_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  rdpg_pkg::sq_bus_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output rdpg_pkg::sq_bus_t out_data
);
    import rdpg_pkg::*;

    localparam int SH_W = REM_W + 2;

    logic            valid_reg;
    sq_bus_t         data_reg, data_next;
    logic [SH_W-1:0] rem_sh, trial;
    logic            take;

    assign in_ready = !valid_reg || out_ready;

    // Trial subtract of 4*root+1 from the shifted remainder.
    always_comb begin
        rem_sh            = {in_data.rem, in_data.rad[RAD_W-1 -: 2]};
        trial             = {1'b0, in_data.root, 2'b01};
        take              = rem_sh >= trial;
        data_next.in_disk = in_data.in_disk;
        data_next.rad     = {in_data.rad[RAD_W-3:0], 2'b00};
        data_next.rem     = take ? REM_W'(rem_sh - trial) : rem_sh[REM_W-1:0];
        data_next.root    = {in_data.root[ROOT_W-2:0], take};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> hw/rtl/radial_disk_pixel_generator_top.sv
// ----------------------------------------------------------------------------
// radial_disk_pixel_generator_top: radial disk test pattern pixel source
// Gives the grey level of a disk centred on the image for each pixel request.
// ----------------------------------------------------------------------------
// One pixel request is taken every clock while s_ready is high, and one grey
// level leaves for each, in order. The path is three front-end stages (offsets,
// squares, disk compare) and a chain of 12 square root cells, one root bit per cell.
// While m_ready is high the chain hands each request on every cycle, so throughput is one pixel
// per clock; empty stages soak up output stalls before the input stalls.
// Inside the disk the level is 255 minus the floor root of the squared
// distance, modulo 256; outside it is 0. Configuration writes are taken
// immediately and must only happen while no request is in flight.
module radial_disk_pixel_generator_top #(
    parameter int COORD_BITS = 12
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Configuration write port.
    input  logic                             cfg_wen,
    input  logic [rdpg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rdpg_pkg::DIM_W-1:0]       cfg_wdata,
    // Pixel requests.
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [COORD_BITS-1:0]            s_pixel_col,
    input  logic [COORD_BITS-1:0]            s_pixel_row,
    // Grey levels.
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [rdpg_pkg::GREY_W-1:0]      m_grey_level
);
    import rdpg_pkg::*;

    logic [DIM_W-1:0]    image_width_reg, image_height_reg;
    logic [RADIUS_W-1:0] disk_radius_reg;
    logic [RAD_W-1:0]    radius_sq_reg, radius_sq_next;

    logic    cell_valid [ROOT_W+1];
    logic    cell_ready [ROOT_W+1];
    sq_bus_t cell_data  [ROOT_W+1];
    sq_bus_t last;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= IMAGE_WIDTH_RST;
            image_height_reg <= IMAGE_HEIGHT_RST;
            disk_radius_reg  <= DISK_RADIUS_RST;
        end else if (cfg_wen) begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_wdata;
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg_wdata;
                CFG_DISK_RADIUS:  disk_radius_reg  <= cfg_wdata[RADIUS_W-1:0];
                default: ;
            endcase
        end
    end

    // Radius squared, kept registered off the pixel path.
    assign radius_sq_next = RAD_W'(disk_radius_reg) * RAD_W'(disk_radius_reg);

    always_ff @(posedge aclk) begin
        radius_sq_reg <= radius_sq_next;
    end

    // Distance front end.
    rdpg_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_valid),
        .in_ready     (s_ready),
        .pixel_col    (s_pixel_col),
        .pixel_row    (s_pixel_row),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .radius_sq    (radius_sq_reg),
        .out_valid    (cell_valid[0]),
        .out_ready    (cell_ready[0]),
        .out_data     (cell_data[0])
    );

    // Square root cell chain, most significant root bit first.
    for (genvar i = 0; i < ROOT_W; i++) begin : g_cell
        rdpg_sqrt_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (cell_valid[i]),
            .in_ready  (cell_ready[i]),
            .in_data   (cell_data[i]),
            .out_valid (cell_valid[i+1]),
            .out_ready (cell_ready[i+1]),
            .out_data  (cell_data[i+1])
        );
    end

    // Grey level from the finished root.
    assign last               = cell_data[ROOT_W];
    assign m_valid            = cell_valid[ROOT_W];
    assign cell_ready[ROOT_W] = m_ready;
    assign m_grey_level       = last.in_disk ? (GREY_MAX - last.root[GREY_W-1:0]) : '0;

endmodule
